/* design/ftsp_pkg.sv */
// Package for the fixed-timestep step pacer: types, codes and reset constants.
`default_nettype none
package ftsp_pkg;

    localparam int TS_W          = 48;
    localparam int CFG_W         = 32;
    localparam int COUNTER_BITS_DEF = 48;
    localparam int DIV_ITERS     = 64;

    localparam logic [31:0] STEP_RST = 32'd166667;
    localparam logic [31:0] TOL_RST  = 32'd16667;
    localparam logic [3:0]  MIN_RST  = 4'd1;
    localparam logic [3:0]  MAX_RST  = 4'd3;
    localparam logic [16:0] ALPHA_ONE = 17'h10000;

    // register indexes
    localparam logic [1:0] REG_STEP = 2'd0;
    localparam logic [1:0] REG_TOL  = 2'd1;
    localparam logic [1:0] REG_MIN  = 2'd2;
    localparam logic [1:0] REG_MAX  = 2'd3;

    // actions
    localparam logic [1:0] ACT_FRAME  = 2'd0;
    localparam logic [1:0] ACT_REBASE = 2'd1;
    localparam logic [1:0] ACT_SETRUN = 2'd2;

    // frame types
    localparam logic [1:0] FT_SINGLE   = 2'd0;
    localparam logic [1:0] FT_UNCAPPED = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [47:0] timestamp;
        logic        paused;
        logic [1:0]  frame_type;
        logic [3:0]  extra_updates;
        logic [31:0] steps_value;
    } in_t;

    typedef struct packed {
        logic [3:0]  steps_required;
        logic [16:0] alpha;
        logic        real_time;
    } out_t;

    typedef enum logic [4:0] {
        S_IDLE, S_ACC, S_MUL, S_DEBT, S_DIVLD, S_DIV, S_DECIDE, S_ADJMUL,
        S_ADJ1, S_ADJ2, S_RMUL, S_REM1, S_REM2, S_ALD, S_ADIV, S_AFIN, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        MB_RUN, MB_COEF, MB_STEPS
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     rebase;
        logic     set_run;
        logic     acc;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     debt;
        logic     divld;
        logic     div_step;
        logic     decide;
        logic     adj1;
        logic     adj2;
        logic     rem1;
        logic     rem2;
        logic     ald;
        logic     afin;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic div_last;
        logic need_adiv;
    } status_t;

endpackage
`default_nettype wire

/* design/fixed_timestep_step_pacer.sv */
// Top level of the fixed-timestep step pacer.
//
//  port group   dir  handshake            payload
//  in_*         in   in_valid / in_stall   in_t  (one frame or control item)
//  out_*        out  out_valid / out_stall out_t (steps, alpha, real-time flag)
//  cfg_*        in   cfg_we               cfg_index, cfg_data
//
// A frame item makes two passes of the shared 64-iteration restoring divider
// (step count, then alpha) between sequencing states, and the alpha pass is
// skipped when alpha needs no divide; no new item is taken until it is done.
// A first frame skips both passes; rebase and steps-run writes take effect at accept.
// Reset restores the register defaults and clears the timing state at once.
// A finished result sits in the output register while the next item is taken;
// a new result waits in its final state until that register is free.
`default_nettype none
module fixed_timestep_step_pacer
    import ftsp_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cmd_t    cmd;
    status_t st;

    ftsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_data.action),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    ftsp_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

/* design/ftsp_ctrl.sv */
// Controller state machine of the step pacer.
`default_nettype none
module ftsp_ctrl
    import ftsp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic [1:0] in_action,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    input  wire status_t st,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept, slot_free;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept && in_action == ACT_FRAME) state_next = S_ACC;
            S_ACC:    state_next = st.first ? S_OUT : S_MUL;
            S_MUL:    state_next = S_DEBT;
            S_DEBT:   state_next = S_DIVLD;
            S_DIVLD:  state_next = S_DIV;
            S_DIV:    if (st.div_last) state_next = S_DECIDE;
            S_DECIDE: state_next = S_ADJMUL;
            S_ADJMUL: state_next = S_ADJ1;
            S_ADJ1:   state_next = S_ADJ2;
            S_ADJ2:   state_next = S_RMUL;
            S_RMUL:   state_next = S_REM1;
            S_REM1:   state_next = S_REM2;
            S_REM2:   state_next = S_ALD;
            S_ALD:    state_next = st.need_adiv ? S_ADIV : S_OUT;
            S_ADIV:   if (st.div_last) state_next = S_AFIN;
            S_AFIN:   state_next = S_OUT;
            S_OUT:    if (slot_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.mul_sel = MB_RUN;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load    = accept && in_action == ACT_FRAME;
                cmd.rebase  = accept && in_action == ACT_REBASE;
                cmd.set_run = accept && in_action == ACT_SETRUN;
            end
            S_ACC:    cmd.acc = 1'b1;
            S_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MB_RUN;
            end
            S_DEBT:   cmd.debt = 1'b1;
            S_DIVLD:  cmd.divld = 1'b1;
            S_DIV:    cmd.div_step = 1'b1;
            S_DECIDE: cmd.decide = 1'b1;
            S_ADJMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MB_COEF;
            end
            S_ADJ1:   cmd.adj1 = 1'b1;
            S_ADJ2:   cmd.adj2 = 1'b1;
            S_RMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MB_STEPS;
            end
            S_REM1:   cmd.rem1 = 1'b1;
            S_REM2:   cmd.rem2 = 1'b1;
            S_ALD:    cmd.ald = 1'b1;
            S_ADIV:   cmd.div_step = 1'b1;
            S_AFIN:   cmd.afin = 1'b1;
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:  cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* design/ftsp_dp.sv */
// Datapath of the step pacer: timing state, multiplier, shared divider, result.
`default_nettype none
module ftsp_dp
    import ftsp_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire in_t         in_data,
    input  wire cmd_t        cmd,
    output status_t          st,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output out_t             out_data
);

    // configuration
    logic [31:0] step_cfg_reg, tol_reg;
    logic [3:0]  min_reg, max_reg;

    // timing state
    logic [63:0]             total_reg;
    logic [COUNTER_BITS-1:0] prev_time_reg;
    logic [31:0]             run_reg;
    logic [3:0]              prev_req_reg;
    logic                    rrt_reg, first_reg;

    // item and working registers
    in_t         item_reg;
    logic [63:0] mul_reg, base_reg, debt_reg, rem_reg;
    logic [63:0] dq_reg;
    logic [31:0] drem_reg;
    logic [5:0]  cnt_reg;
    logic [3:0]  r_reg;
    logic [5:0]  k_reg;
    logic        clamp_adj_reg;
    logic [16:0] alpha_reg;
    out_t        out_reg;

    logic [31:0]             step;
    logic                    decoupled;
    logic [63:0]             ts64;
    logic [COUNTER_BITS-1:0] ts_c, elapsed;
    logic [31:0]             mul_b;
    logic [5:0]              kabs;
    logic [32:0]             shifted;
    logic                    ge;
    logic [63:0]             dividend;
    logic [64:0]             req65;
    logic                    clamp;
    logic [3:0]              r_base, r1, r2;
    logic signed [5:0]       hd, e, k;
    logic                    extra_on;

    assign step      = (step_cfg_reg == 32'd0) ? 32'd1 : step_cfg_reg;
    assign decoupled = (min_reg == 4'd0);
    assign ts64      = 64'(item_reg.timestamp);
    assign ts_c      = ts64[COUNTER_BITS-1:0];
    assign elapsed   = ts_c - prev_time_reg;

    assign shifted = {drem_reg, dq_reg[63]};
    assign ge      = (shifted >= {1'b0, step});

    assign st.first     = first_reg && !item_reg.paused;
    assign st.div_last  = (cnt_reg == 6'(DIV_ITERS - 1));
    assign st.need_adiv = decoupled && !item_reg.paused && !rem_reg[63]
                          && (rem_reg != 64'd0) && (rem_reg < 64'(step));

    assign kabs = k_reg[5] ? 6'(-k_reg) : k_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            MB_RUN:   mul_b = run_reg;
            MB_COEF:  mul_b = 32'(kabs);
            MB_STEPS: mul_b = 32'(r_reg);
            default:  mul_b = 32'd0;
        endcase
    end

    // divider dividend for the step count
    always_comb
    begin
        dividend = 64'd0;
        if (decoupled)
        begin
            if ($signed(debt_reg) > 64'sd0)
                dividend = debt_reg;
        end
        else if ($signed(debt_reg) > $signed({32'd0, tol_reg}))
        begin
            dividend = debt_reg - 64'(tol_reg) + 64'(step) - 64'd1;
        end
    end

    // step decision
    always_comb
    begin
        req65    = {1'b0, dq_reg} + 65'(min_reg);
        clamp    = req65 > 65'(max_reg);
        r_base   = clamp ? max_reg : req65[3:0];
        r1       = (item_reg.frame_type == FT_SINGLE) ? min_reg : r_base;
        hd       = $signed(6'(max_reg)) - $signed(6'(min_reg));
        e        = ($signed(6'(item_reg.extra_updates)) >= hd) ? hd
                   : $signed(6'(item_reg.extra_updates));
        extra_on = (item_reg.extra_updates != 4'd0) && (r1 == min_reg);
        r2       = extra_on ? r1 + e[3:0] : r1;
        k        = ((clamp && item_reg.frame_type != FT_UNCAPPED && !item_reg.paused)
                    ? hd : 6'sd0) + (extra_on ? e : 6'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cfg_reg  <= STEP_RST;
            tol_reg       <= TOL_RST;
            min_reg       <= MIN_RST;
            max_reg       <= MAX_RST;
            total_reg     <= '0;
            prev_time_reg <= '0;
            run_reg       <= '0;
            prev_req_reg  <= '0;
            rrt_reg       <= 1'b1;
            first_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STEP: step_cfg_reg <= cfg_data;
                    REG_TOL:  tol_reg      <= cfg_data;
                    REG_MIN:  min_reg      <= cfg_data[3:0];
                    REG_MAX:  max_reg      <= cfg_data[3:0];
                    default:  ;
                endcase
            end
            if (cmd.rebase)
            begin
                total_reg     <= '0;
                prev_time_reg <= '0;
                run_reg       <= '0;
                prev_req_reg  <= '0;
                rrt_reg       <= 1'b1;
                first_reg     <= 1'b1;
            end
            if (cmd.set_run)
                run_reg <= in_data.steps_value;
            if (cmd.acc)
            begin
                prev_time_reg <= ts_c;
                if (st.first)
                begin
                    first_reg    <= 1'b0;
                    prev_req_reg <= min_reg;
                end
                else if (!item_reg.paused)
                begin
                    run_reg   <= run_reg + 32'(prev_req_reg);
                    total_reg <= total_reg + 64'(elapsed);
                end
            end
            if (cmd.decide)
            begin
                rrt_reg <= !clamp;
                if (!item_reg.paused)
                    prev_req_reg <= r_base;
            end
            if (cmd.adj1)
                total_reg <= k_reg[5] ? total_reg - mul_reg : total_reg + mul_reg;
            if (cmd.adj2 && clamp_adj_reg)
                total_reg <= total_reg - debt_reg;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_data;
        if (cmd.acc && st.first)
        begin
            r_reg     <= min_reg;
            alpha_reg <= ALPHA_ONE;
        end
        if (cmd.mul_en)
            mul_reg <= 64'(step) * 64'(mul_b);
        if (cmd.debt)
        begin
            base_reg <= mul_reg;
            debt_reg <= item_reg.paused ? '1 : total_reg - mul_reg;
        end
        if (cmd.divld)
        begin
            dq_reg   <= dividend;
            drem_reg <= '0;
            cnt_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            drem_reg <= ge ? 32'(shifted - {1'b0, step}) : shifted[31:0];
            dq_reg   <= {dq_reg[62:0], ge};
            cnt_reg  <= cnt_reg + 6'd1;
        end
        if (cmd.decide)
        begin
            r_reg         <= r2;
            k_reg         <= k;
            clamp_adj_reg <= clamp && item_reg.frame_type != FT_UNCAPPED
                             && !item_reg.paused;
        end
        if (cmd.rem1)
            rem_reg <= total_reg - base_reg;
        if (cmd.rem2)
            rem_reg <= rem_reg - mul_reg;
        if (cmd.ald)
        begin
            dq_reg   <= {16'd0, rem_reg[31:0], 16'd0};
            drem_reg <= '0;
            cnt_reg  <= '0;
            if (!decoupled || item_reg.paused)
                alpha_reg <= ALPHA_ONE;
            else if (rem_reg[63] || rem_reg == 64'd0)
                alpha_reg <= '0;
            else
                alpha_reg <= ALPHA_ONE;
        end
        if (cmd.afin)
            alpha_reg <= {1'b0, dq_reg[15:0]};
        if (cmd.out_load)
        begin
            out_reg.steps_required <= r_reg;
            out_reg.alpha          <= alpha_reg;
            out_reg.real_time      <= rrt_reg;
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Testbench for the fixed-timestep step pacer: random frames checked against a built-in predictor.
`timescale 1ns / 1ps
module testbench;
    import ftsp_pkg::*;

    class pacer_scoreboard;
        logic [31:0] step_len, tol_len;
        logic [3:0]  min_st, max_st;
        logic [63:0] total_time;
        logic [47:0] prev_time;
        logic [31:0] steps_run;
        logic [3:0]  prev_req;
        bit          running_rt, first_pass;
        out_t        pending[$];
        int          mismatches;

        function new();
            step_len = STEP_RST;
            tol_len = TOL_RST;
            min_st = MIN_RST;
            max_st = MAX_RST;
            mismatches = 0;
            rebase();
        endfunction

        function void rebase();
            total_time = 0;
            prev_time = 0;
            steps_run = 0;
            prev_req = 0;
            running_rt = 1;
            first_pass = 1;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_STEP: step_len = val;
                REG_TOL:  tol_len = val;
                REG_MIN:  min_st = val[3:0];
                default:  max_st = val[3:0];
            endcase
        endfunction

        function void note_input(in_t t);
            logic [63:0] step, debt, req, d, rem;
            longint      sdebt, srem;
            int          mn, mx, r, extra, head;
            bit          decoupled;
            out_t        o;
            step = (step_len == 0) ? 64'd1 : {32'd0, step_len};
            mn = min_st;
            mx = max_st;
            decoupled = (min_st == 0);
            sdebt = -1;
            o.alpha = ALPHA_ONE;
            if (t.action == ACT_REBASE)
            begin
                rebase();
                return;
            end
            if (t.action == ACT_SETRUN)
            begin
                steps_run = t.steps_value;
                return;
            end
            if (t.action != ACT_FRAME)
                return;
            if (!t.paused && first_pass)
            begin
                first_pass = 0;
                prev_req = min_st;
                prev_time = t.timestamp;
                o.steps_required = min_st;
                o.real_time = running_rt;
                pending.push_back(o);
                return;
            end
            if (!t.paused)
            begin
                steps_run += prev_req;
                total_time += {16'd0, t.timestamp - prev_time};
                debt = total_time - step * {32'd0, steps_run};
                sdebt = debt;
            end
            prev_time = t.timestamp;
            req = min_st;
            if (decoupled)
                req = (sdebt > 0) ? 64'(sdebt) / step : 0;
            else if (sdebt > longint'({32'd0, tol_len}))
            begin
                d = 64'(sdebt) - tol_len;
                req = min_st + (d + step - 1) / step;
            end
            if (req > max_st)
            begin
                req = max_st;
                running_rt = 0;
                if (t.frame_type != FT_UNCAPPED && !t.paused)
                    total_time = total_time + 64'(longint'(mx - mn)) * step - 64'(sdebt);
            end
            else
                running_rt = 1;
            r = int'(req);
            if (!t.paused)
                prev_req = r[3:0];
            if (t.frame_type == FT_SINGLE)
                r = mn;
            extra = t.extra_updates;
            if (extra > 0 && r == mn)
            begin
                head = mx - mn;
                if (extra >= head)
                    extra = head;
                r += extra;
                total_time = total_time + 64'(longint'(extra)) * step;
            end
            if (decoupled && !t.paused)
            begin
                rem = total_time - step * {32'd0, steps_run} - step * 64'(unsigned'(r));
                srem = rem;
                if (srem <= 0)
                    o.alpha = 0;
                else if (rem >= step)
                    o.alpha = ALPHA_ONE;
                else
                    o.alpha = 17'((rem << 16) / step);
            end
            o.steps_required = r[3:0];
            o.real_time = running_rt;
            pending.push_back(o);
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result error: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 0;
    out_t        out_data;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    pacer_scoreboard sb = new();
    logic [47:0] clock_now = 0;
    bit          no_idle = 0;
    bit          hold_long = 0;
    int          cycles = 0;
    int          frames_sent = 0;

    always #5 clk = ~clk;

    fixed_timestep_step_pacer dut (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("fixed_timestep_step_pacer: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);

    // receiver stall: random bursts, or a long hold when asked
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                out_stall <= 1;
                for (n = 0; n < 3000; n++)
                    @(negedge clk);
                out_stall <= 0;
                hold_long = 0;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1;
                n = $urandom_range(1, 8);
                repeat (n) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    // valid stays high after a transaction until the next one or an idle gap
    task automatic send(in_t t);
        if (!no_idle && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_data <= t;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        sb.note_input(t);
        @(negedge clk);
    endtask

    // write enable is dropped by the caller after the last write
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    function automatic in_t make_frame(int lo, int hi);
        in_t t;
        t = '0;
        t.action = ACT_FRAME;
        clock_now += 48'($urandom_range(lo, hi));
        t.timestamp = clock_now;
        t.paused = ($urandom_range(0, 9) == 0);
        t.frame_type = $urandom_range(0, 3);
        t.extra_updates = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
        t.steps_value = $urandom;
        return t;
    endfunction

    initial
    begin
        in_t t;
        int ph, i, kind;
        logic [31:0] st;
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: first frame, pause, extremes, each action and frame type
        t = '0;
        t.action = ACT_FRAME;
        t.paused = 1;
        send(t);
        t.paused = 0;
        send(t);
        for (i = 0; i < 4; i++)
        begin
            t.frame_type = i;
            t.extra_updates = (i == 1) ? 4'hf : 4'd0;
            clock_now += 200000 + i * 150000;
            t.timestamp = clock_now;
            send(t);
        end
        t.timestamp = 48'hffff_ffff_ffff;
        send(t);
        t.timestamp = 48'd5;
        clock_now = 5;
        send(t);
        t.action = ACT_SETRUN;
        t.steps_value = 32'hffff_ffff;
        send(t);
        t.action = 2'd3;
        send(t);
        t.action = ACT_FRAME;
        t.timestamp = 48'd400000;
        clock_now = t.timestamp;
        send(t);
        t.action = ACT_REBASE;
        send(t);
        drain();

        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: st = 1;
                1: st = 32'hffff_ffff;
                2: st = 0;
                default: st = $urandom_range(100, 5000);
            endcase
            write_reg(REG_STEP, st);
            write_reg(REG_TOL, (ph == 1) ? 32'hffff_ffff : ((ph == 2) ? 0 : $urandom_range(0, 3000)));
            write_reg(REG_MIN, (ph == 2) ? 4'd15 : ((ph % 2) ? 4'd0 : $urandom_range(0, 4)));
            write_reg(REG_MAX, (ph == 1) ? 4'd15 : ((ph == 3) ? 4'd0 : $urandom_range(1, 15)));
            cfg_we <= 0;
            if (ph == 6)
                no_idle = 1;
            for (i = 0; i < 200; i++)
            begin
                kind = $urandom_range(0, 99);
                if (i == 50 && ph == 4)
                    hold_long = 1;
                if (i == 100 && ph == 5)
                begin
                    in_valid <= 0;
                    while (sb.pending.size() != 0)
                        @(negedge clk);
                end
                if (kind < 88)
                    t = make_frame(0, (ph == 1) ? 32'h7fff_ffff : st * 6 + 10);
                else if (kind < 92)
                begin
                    t = '0;
                    t.action = ACT_REBASE;
                    t.timestamp = $urandom;
                    clock_now = 0;
                end
                else if (kind < 97)
                begin
                    t = make_frame(0, 10);
                    t.action = ACT_SETRUN;
                end
                else
                begin
                    t = make_frame(0, 10);
                    t.action = 2'd3;
                    t.timestamp = {$urandom, $urandom};
                    t.paused = $urandom;
                end
                send(t);
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("fixed_timestep_step_pacer: match");
        else
            $display("fixed_timestep_step_pacer: mismatch");
        $finish;
    end
endmodule
